### hw/rtl/gsig_pkg.sv
// Shared types and constants for the grid strip index generator.
// No dependencies; imported by every module of the block.
package gsig_pkg;

    localparam int GRID_MAX_DEF = 256;   // default largest rows / row length
    localparam int CFG_W        = 9;     // width of the size registers
    localparam int STITCH_W     = 2;     // width of the stitch registers
    localparam int CFG_IDX_W    = 2;     // register index width
    localparam int IDX_W        = 16;    // vertex index width

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STITCH_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STITCH_COLUMNS = 2'd3;

    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd2;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 9'd2;

    // Strip walk phase
    typedef enum logic [3:0] {
        PH_LEFT  = 4'b0001,
        PH_RIGHT = 4'b0010,
        PH_TRAIL = 4'b0100,
        PH_LEAD  = 4'b1000
    } t_phase;

    // Clamped grid settings handed to the walker
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic             rows_first;   // stitch first row
        logic             rows_last;    // stitch last row
        logic             cols_first;   // stitch first column
        logic             cols_last;    // stitch last column
    } t_grid_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             last;
    } t_result;

endpackage

### hw/rtl/gsig_cfg.sv
// Configuration registers of the grid strip index generator.
// Holds raw writes and presents clamped sizes and decoded stitch flags; uses gsig_pkg.
module gsig_cfg
    import gsig_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_grid_cfg            o_grid_cfg
);

    localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(GRID_MAX);

    logic [CFG_W-1:0]    r_row_count;
    logic [CFG_W-1:0]    r_row_length;
    logic [STITCH_W-1:0] r_stitch_rows;
    logic [STITCH_W-1:0] r_stitch_columns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count      <= SIZE_RESET;
            r_row_length     <= SIZE_RESET;
            r_stitch_rows    <= '0;
            r_stitch_columns <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:      r_row_count      <= i_cfg_data;
                CFG_ROW_LENGTH:     r_row_length     <= i_cfg_data;
                CFG_STITCH_ROWS:    r_stitch_rows    <= i_cfg_data[STITCH_W-1:0];
                CFG_STITCH_COLUMNS: r_stitch_columns <= i_cfg_data[STITCH_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < SIZE_MIN) res = SIZE_MIN;
        if (v > SIZE_MAX) res = SIZE_MAX;
        return res;
    endfunction

    // Any negative code means the first edge
    always_comb begin
        o_grid_cfg.rows       = clamp_size(r_row_count);
        o_grid_cfg.cols       = clamp_size(r_row_length);
        o_grid_cfg.rows_first = r_stitch_rows[1];
        o_grid_cfg.rows_last  = (r_stitch_rows == 2'b01);
        o_grid_cfg.cols_first = r_stitch_columns[1];
        o_grid_cfg.cols_last  = (r_stitch_columns == 2'b01);
    end

endmodule

### hw/rtl/gsig_walk.sv
// Strip position state and index computation of the grid strip index generator.
// One row-base multiply feeds a few adds; the position advances on i_advance. Uses gsig_pkg.
module gsig_walk
    import gsig_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  logic      i_restart,
    input  t_grid_cfg i_grid_cfg,
    output t_result   o_result
);

    localparam int POS_W  = $clog2(GRID_MAX);
    localparam int PROD_W = POS_W + CFG_W;

    logic [POS_W-1:0] r_row_pos;
    logic [POS_W-1:0] r_column_pos;
    t_phase           r_phase;
    logic [POS_W-1:0] n_row_pos;
    logic [POS_W-1:0] n_column_pos;
    t_phase           n_phase;

    logic [CFG_W-1:0]  last_pair;
    logic              pos_bad;
    logic [POS_W-1:0]  i_row;
    logic [POS_W-1:0]  j_col;
    t_phase            ph;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  cols_x;
    logic [IDX_W-1:0]  j_x;
    logic [IDX_W-1:0]  up;
    logic              odd_i;
    logic              j_at_end;
    logic              at_last_pair;
    logic [CFG_W-1:0]  j_plus;

    always_comb begin
        last_pair = i_grid_cfg.rows - SIZE_MIN;
        pos_bad = (CFG_W'(r_row_pos) > last_pair)
               || (CFG_W'(r_column_pos) >= i_grid_cfg.cols)
               || (r_phase == PH_LEAD && r_row_pos == '0)
               || (r_phase == PH_TRAIL && CFG_W'(r_row_pos) >= last_pair);

        // Fall back to the first index on request or when the position is stale
        if (i_restart || pos_bad) begin
            i_row = '0;
            j_col = '0;
            ph    = PH_LEFT;
        end else begin
            i_row = r_row_pos;
            j_col = r_column_pos;
            ph    = r_phase;
        end

        prod         = PROD_W'(i_row) * PROD_W'(i_grid_cfg.cols);
        base         = IDX_W'(prod);
        cols_x       = IDX_W'(i_grid_cfg.cols);
        j_x          = IDX_W'(j_col);
        up           = base + cols_x;
        odd_i        = i_row[0];
        j_at_end     = (CFG_W'(j_col) == i_grid_cfg.cols - 9'd1);
        at_last_pair = (CFG_W'(i_row) == last_pair);
        j_plus       = CFG_W'(j_col) + 9'd1;

        n_row_pos    = i_row;
        n_column_pos = j_col;
        n_phase      = ph;
        o_result.vertex_index = base;
        o_result.last         = 1'b0;

        case (ph)
            PH_LEAD: begin
                o_result.vertex_index = base;
                if (i_grid_cfg.cols_first && odd_i) o_result.vertex_index = base - cols_x;
                n_phase = PH_LEFT;
            end
            PH_LEFT: begin
                o_result.vertex_index = base + j_x;
                if (i_grid_cfg.cols_first && j_col == '0 && odd_i)
                    o_result.vertex_index = base - cols_x;
                if (i_grid_cfg.cols_last && j_at_end && odd_i)
                    o_result.vertex_index = base - cols_x + j_x;
                if (i_grid_cfg.rows_first && j_col[0] && i_row == '0)
                    o_result.vertex_index = base + j_x - 16'd1;
                n_phase = PH_RIGHT;
            end
            PH_RIGHT: begin
                // odd_next is the complement of odd_i
                o_result.vertex_index = up + j_x;
                if (i_grid_cfg.cols_first && j_col == '0 && !odd_i)
                    o_result.vertex_index = base;
                if (i_grid_cfg.cols_last && j_at_end && !odd_i)
                    o_result.vertex_index = base + j_x;
                if (i_grid_cfg.rows_last && j_col[0] && at_last_pair)
                    o_result.vertex_index = up + j_x - 16'd1;
                if (j_plus < i_grid_cfg.cols) begin
                    n_column_pos = POS_W'(j_plus);
                    n_phase      = PH_LEFT;
                end else if (CFG_W'(i_row) < last_pair) begin
                    n_phase = PH_TRAIL;
                end else begin
                    o_result.last = 1'b1;
                    n_row_pos     = '0;
                    n_column_pos  = '0;
                    n_phase       = PH_LEFT;
                end
            end
            PH_TRAIL: begin
                o_result.vertex_index = up + cols_x - 16'd1;
                if (i_grid_cfg.cols_last && !odd_i)
                    o_result.vertex_index = base + cols_x - 16'd1;
                n_row_pos    = i_row + POS_W'(1);
                n_column_pos = '0;
                n_phase      = PH_LEAD;
            end
            default: begin
                n_row_pos    = '0;
                n_column_pos = '0;
                n_phase      = PH_LEFT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos    <= '0;
            r_column_pos <= '0;
            r_phase      <= PH_LEFT;
        end else if (i_advance) begin
            r_row_pos    <= n_row_pos;
            r_column_pos <= n_column_pos;
            r_phase      <= n_phase;
        end
    end

endmodule

### hw/rtl/grid_strip_index_generator_core.sv
// Grid strip index generator: one vertex index of a row-major triangle strip per transaction.
// Latency: a result passes the input register and then the output register; a stalled output holds it back.
// Throughput: one transaction per cycle while the output is not stalled.
// The output register frees its slot in the same cycle it is taken, so flow is continuous.
// Reset (synchronous, active low) clears the position, the pipeline valids and the configuration registers.
// Uses gsig_pkg, gsig_cfg and gsig_walk.
module grid_strip_index_generator_core
    import gsig_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_W-1:0]     o_vertex_index,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_grid_cfg grid_cfg;
    t_result   result;

    logic             r_s1_valid;
    logic             r_s1_restart;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_vertex_index;
    logic             r_last;

    logic out_free;
    logic advance;
    logic in_accept;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;

    gsig_cfg #(
        .GRID_MAX (GRID_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_grid_cfg  (grid_cfg)
    );

    gsig_walk #(
        .GRID_MAX (GRID_MAX)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_restart  (r_s1_restart),
        .i_grid_cfg (grid_cfg),
        .o_result   (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_restart <= i_restart;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_vertex_index <= result.vertex_index;
            r_last         <= result.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_vertex_index;
    assign o_last         = r_last;

endmodule

### tb/sv/grid_strip_index_generator_core_tb.sv
// Self-checking bench for the grid strip index generator: walks small, clamped, stitched
// and tall grids and checks every vertex index against a strip walker kept here.
// Depends on gsig_pkg and grid_strip_index_generator_core.
module grid_strip_index_generator_core_tb;
    import gsig_pkg::*;

    localparam int GRID_MAX    = GRID_MAX_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int MAX_REPORTS = 10;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_restart = 1'b0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = CFG_ROW_COUNT;
    logic [CFG_W-1:0]     cfg_dat    = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic [IDX_W-1:0]     vertex_index;
    logic                 last;
    logic                 cfg_ready;

    // grid settings and strip position as the block should hold them
    logic [CFG_W-1:0]    grid_rows = SIZE_RESET;
    logic [CFG_W-1:0]    grid_cols = SIZE_RESET;
    logic [STITCH_W-1:0] stitch_r  = '0;
    logic [STITCH_W-1:0] stitch_c  = '0;
    int unsigned         walk_row  = 0;
    int unsigned         walk_col  = 0;
    t_phase              walk_ph   = PH_LEFT;

    logic    restart_pending[$];
    t_result strip_expected[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          long_hold_arm  = 1'b0;
    bit          out_hold_on    = 1'b0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    grid_strip_index_generator_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_restart      (in_restart),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_vertex_index (vertex_index),
        .o_last         (last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_dat)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Next index of the strip; advances the walk position.
    function automatic t_result strip_next(input logic restart);
        int unsigned rows, cols, last_pair, i, j, idx;
        logic        odd_i, odd_n, fin, col_first, col_last, row_first, row_last;
        t_result     res;
        rows = (grid_rows < SIZE_MIN) ? SIZE_MIN : ((grid_rows > GRID_MAX) ? GRID_MAX : grid_rows);
        cols = (grid_cols < SIZE_MIN) ? SIZE_MIN : ((grid_cols > GRID_MAX) ? GRID_MAX : grid_cols);
        // any negative stitch code folds the first edge
        row_first = stitch_r[1];
        row_last  = (stitch_r == 2'b01);
        col_first = stitch_c[1];
        col_last  = (stitch_c == 2'b01);
        last_pair = rows - 2;
        fin = 1'b0;
        idx = 0;
        if (restart || walk_row > last_pair || walk_col >= cols ||
            (walk_ph == PH_LEAD && walk_row == 0) ||
            (walk_ph == PH_TRAIL && walk_row >= last_pair)) begin
            walk_row = 0;
            walk_col = 0;
            walk_ph  = PH_LEFT;
        end
        i = walk_row;
        j = walk_col;
        odd_i = i[0];
        odd_n = ~i[0];
        case (walk_ph)
            PH_LEAD: begin
                idx = i * cols;
                if (col_first && odd_i) idx = (i - 1) * cols;
                walk_ph = PH_LEFT;
            end
            PH_LEFT: begin
                idx = i * cols + j;
                if (col_first && j == 0 && odd_i) idx = (i - 1) * cols;
                if (col_last && j == cols - 1 && odd_i) idx = (i - 1) * cols + j;
                if (row_first && j[0] && i == 0) idx = i * cols + (j - 1);
                walk_ph = PH_RIGHT;
            end
            PH_RIGHT: begin
                idx = (i + 1) * cols + j;
                if (col_first && j == 0 && odd_n) idx = i * cols;
                if (col_last && j == cols - 1 && odd_n) idx = i * cols + j;
                if (row_last && j[0] && i == last_pair) idx = (i + 1) * cols + (j - 1);
                if (j + 1 < cols) begin
                    walk_col = j + 1;
                    walk_ph  = PH_LEFT;
                end else if (i < last_pair) begin
                    walk_ph = PH_TRAIL;
                end else begin
                    fin      = 1'b1;
                    walk_row = 0;
                    walk_col = 0;
                    walk_ph  = PH_LEFT;
                end
            end
            default: begin
                idx = (i + 1) * cols + (cols - 1);
                if (col_last && odd_n) idx = i * cols + (cols - 1);
                walk_row = i + 1;
                walk_col = 0;
                walk_ph  = PH_LEAD;
            end
        endcase
        res.vertex_index = idx[IDX_W-1:0];
        res.last         = fin;
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return CFG_W'($urandom_range(0, 7));
        if (r < 8) return CFG_W'($urandom_range(8, 40));
        return CFG_W'($urandom_range(200, 511));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_dat   <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_COUNT:      grid_rows = data;
            CFG_ROW_LENGTH:     grid_cols = data;
            CFG_STITCH_ROWS:    stitch_r  = data[STITCH_W-1:0];
            CFG_STITCH_COLUMNS: stitch_c  = data[STITCH_W-1:0];
            default: ;
        endcase
    endtask

    // hold until every queued transaction is sent and its index has come back
    task automatic drain();
        do @(posedge clk);
        while (restart_pending.size() != 0 || in_valid || strip_expected.size() != 0);
    endtask

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) strip_expected.push_back(strip_next(in_restart));
            if (!in_valid || !in_stall) begin
                if (restart_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid   <= 1'b1;
                    in_restart <= restart_pending.pop_front();
                end else begin
                    in_valid   <= 1'b0;
                    in_restart <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (strip_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("index %0d last %0b arrived with nothing pending",
                                 vertex_index, last);
                end else begin
                    t_result want;
                    want = strip_expected.pop_front();
                    if (vertex_index !== want.vertex_index || last !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: expected index %0d last %0b, got index %0d last %0b",
                                     want.vertex_index, want.last, vertex_index, last);
                    end
                end
            end
            out_stall <= out_hold_on || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin : out_hold_proc
        wait (long_hold_arm);
        @(posedge clk);
        out_hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_hold_on <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("grid_strip_index_generator_core_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned rate;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid: full strip, wrap, then an explicit restart
        repeat (5) restart_pending.push_back(1'b0);
        restart_pending.push_back(1'b1);
        drain();

        // 3x3 with a negative row stitch code of -2 and last-column stitch
        cfg_write(CFG_ROW_COUNT, 9'd3);
        cfg_write(CFG_ROW_LENGTH, 9'd3);
        cfg_write(CFG_STITCH_ROWS, 9'h002);
        cfg_write(CFG_STITCH_COLUMNS, 9'h001);
        restart_pending.push_back(1'b1);
        repeat (13) restart_pending.push_back(1'b0);
        drain();

        // walk a tall narrow grid to the start of its last pair, then widen it in place
        // and run that pair to its final index and past the wrap
        cfg_write(CFG_ROW_COUNT, 9'd96);
        cfg_write(CFG_ROW_LENGTH, 9'd2);
        cfg_write(CFG_STITCH_ROWS, 9'h000);
        cfg_write(CFG_STITCH_COLUMNS, 9'h000);
        repeat (564) restart_pending.push_back(1'b0);
        long_hold_arm = 1'b1;
        drain();
        cfg_write(CFG_ROW_LENGTH, 9'd256);
        repeat (520) restart_pending.push_back(1'b0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            cfg_write(CFG_ROW_COUNT, pick_size());
            cfg_write(CFG_ROW_LENGTH, pick_size());
            cfg_write(CFG_STITCH_ROWS, CFG_W'($urandom_range(0, 511)));
            cfg_write(CFG_STITCH_COLUMNS, CFG_W'($urandom_range(0, 511)));
            rate = (ph == 5) ? 500 : 25;
            repeat (25) restart_pending.push_back($urandom_range(0, 999) < rate);
            // sender pause: let every outstanding index come back mid-phase
            if (ph == 2) drain();
            repeat (25) restart_pending.push_back($urandom_range(0, 999) < rate);
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0 && strip_expected.size() == 0) begin
            $display("grid_strip_index_generator_core_tb passed");
        end else begin
            $display("grid_strip_index_generator_core_tb failed");
        end
        $finish;
    end

endmodule
